@@ src/dms_pkg.sv @@
// shared types, widths and register codes of the dijet mass and eta gap selector
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

  localparam int MOM_W     = 20;
  localparam int E_W       = 19;
  localparam int ETA_W     = 14;
  localparam int GAP_W     = 14;
  localparam int MASS_W    = 19;
  localparam int TALLY_W   = 7;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 1;

  localparam int SUM_W = MOM_W + 1;
  localparam int SQ_W  = 2 * SUM_W;
  localparam int M2_W  = SQ_W + 2;
  localparam int THR_W = 2 * MASS_W;

  localparam int MAX_JETS_DEF = 16;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [GAP_W-1:0]   MIN_ETA_GAP_RST   = 14'd3584;
  localparam logic [MASS_W-1:0]  MIN_PAIR_MASS_RST = 19'd10400;
  localparam logic [TALLY_W-1:0] TALLY_MAX         = 7'd127;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_ETA_GAP   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PAIR_MASS = 1'b1;

  typedef struct packed {
    logic [MOM_W-1:0] x;
    logic [MOM_W-1:0] y;
    logic [MOM_W-1:0] z;
    logic [E_W-1:0]   e;
    logic [ETA_W-1:0] eta;
  } jet_t;

  typedef struct packed {
    jet_t jet;
    logic present;
    logic last;
  } item_t;

endpackage

`default_nettype wire

@@ src/dms_if.sv @@
// request channels of the selector: jets in, event results out
`timescale 1ns / 1ps
`default_nettype none

interface dms_in_if import dms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             jet_present;
  logic [MOM_W-1:0] mom_x;
  logic [MOM_W-1:0] mom_y;
  logic [MOM_W-1:0] mom_z;
  logic [E_W-1:0]   jet_energy;
  logic [ETA_W-1:0] pseudorapidity;
  logic             last_jet;

  modport source (output valid, jet_present, mom_x, mom_y, mom_z, jet_energy,
                  pseudorapidity, last_jet, input ready);
  modport sink (input valid, jet_present, mom_x, mom_y, mom_z, jet_energy,
                pseudorapidity, last_jet, output ready);
endinterface

interface dms_out_if import dms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               event_pass;
  logic [TALLY_W-1:0] good_pair_count;
  logic               jets_dropped;

  modport source (output valid, event_pass, good_pair_count, jets_dropped, input ready);
  modport sink (input valid, event_pass, good_pair_count, jets_dropped, output ready);
endinterface

`default_nettype wire

@@ src/dijet_mass_eta_gap_selector_core.sv @@
// top level of the dijet invariant mass and eta gap event selector
`timescale 1ns / 1ps
`default_nettype none

// Jets of one event arrive one request at a time on jets; the request with
// last_jet set closes the event and produces one request on results with the
// pass flag, the count of good unordered pairs (saturating at 127) and a flag
// telling whether jets beyond MAX_JETS were ignored. A pair is good when the
// eta gap strictly exceeds min_eta_gap, the two etas have strictly opposite
// signs and the squared mass strictly exceeds min_pair_mass squared.
// A jet is stored on arrival and then paired with each jet stored before
// it, one stored jet read per cycle; the back end takes no new request
// meanwhile. The closing request waits while the last pairs drain through
// the four-stage sum/square/compare pipeline. A four-entry request queue
// sits in front; the result register frees the back end once the result
// is loaded, and a later closing request waits until it is taken. Empty
// requests that do not close an event are dropped at the front and never
// reach the back end. The user must write the registers, through
// wr_en / wr_index / wr_data, only while the block is idle (not enforced).

module dijet_mass_eta_gap_selector_core import dms_pkg::*; #(
  parameter int MAX_JETS = MAX_JETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  dms_in_if.sink               jets,
  dms_out_if.source            results,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_W-1:0]     wr_data
);

  logic [GAP_W-1:0]  min_eta_gap;
  logic [MASS_W-1:0] min_pair_mass;
  logic [THR_W-1:0]  thr2;

  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_eta_gap   <= MIN_ETA_GAP_RST;
      min_pair_mass <= MIN_PAIR_MASS_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MIN_ETA_GAP:   min_eta_gap   <= wr_data[GAP_W-1:0];
        REG_MIN_PAIR_MASS: min_pair_mass <= wr_data[MASS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // squared mass threshold, kept current every cycle
  always_ff @(posedge clk) begin
    thr2 <= THR_W'(min_pair_mass) * THR_W'(min_pair_mass);
  end

  // request queue and classification
  dms_front u_front (
    .clk     (clk),
    .rst     (rst),
    .jets    (jets),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // pairing engine and result register
  dms_back #(
    .MAX_JETS (MAX_JETS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .min_eta_gap (min_eta_gap),
    .thr2        (thr2),
    .results     (results)
  );

endmodule

`default_nettype wire

@@ src/dms_front.sv @@
// front end: takes jet requests, drops empty non-closing ones, queues the rest
`timescale 1ns / 1ps
`default_nettype none

module dms_front import dms_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  dms_in_if.sink jets,
  output item_t q_item,
  output logic  q_valid,
  input  logic  q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            fifo [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             accept;
  logic             push;
  logic             pop;
  item_t            in_item;

  assign jets.ready = (count != CNT_W'(QUEUE_DEPTH));
  assign accept     = jets.valid && jets.ready;
  // an item with no jet that does not close the event changes nothing
  assign push       = accept && (jets.jet_present || jets.last_jet);
  assign pop        = q_pop && q_valid;

  always_comb begin
    in_item.jet.x   = jets.mom_x;
    in_item.jet.y   = jets.mom_y;
    in_item.jet.z   = jets.mom_z;
    in_item.jet.e   = jets.jet_energy;
    in_item.jet.eta = jets.pseudorapidity;
    in_item.present = jets.jet_present;
    in_item.last    = jets.last_jet;
  end

  assign q_valid = (count != '0);
  assign q_item  = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/dms_back.sv @@
// back end: jet store, pair test pipeline, tally and result register
`timescale 1ns / 1ps
`default_nettype none

module dms_back import dms_pkg::*; #(
  parameter int MAX_JETS = MAX_JETS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  item_t            q_item,
  input  logic             q_valid,
  output logic             q_pop,
  input  logic [GAP_W-1:0] min_eta_gap,
  input  logic [THR_W-1:0] thr2,
  dms_out_if.source        results
);

  localparam int IDX_W  = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
  localparam int HELD_W = $clog2(MAX_JETS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PAIR  = 2'd1;
  localparam logic [1:0] ST_CLOSE = 2'd2;

  logic [1:0]          state;
  logic [HELD_W-1:0]   held;
  logic [TALLY_W-1:0]  tally;
  logic                overflow;
  jet_t                cur;
  logic                cur_last;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    pair_end;

  jet_t                mem [MAX_JETS];
  jet_t                rd_jet;
  jet_t                c0;

  logic                v0, v1, v2, v3;
  logic signed [SUM_W-1:0] s1_x, s1_y, s1_z, s1_e;
  logic                g1, g2, g3;
  logic signed [SQ_W-1:0]  sq_x, sq_y, sq_z, sq_e;
  logic signed [SQ_W:0]    a3;
  logic [SQ_W:0]           b3;
  logic signed [M2_W-1:0]  m2;
  logic                    good3;

  logic                full;
  logic                busy;
  logic                out_free;
  logic                issue;
  logic                emit;

  logic signed [ETA_W:0] eta_diff;
  logic [ETA_W:0]        eta_gap;
  logic                  cur_neg, cur_pos, old_neg, old_pos;
  logic                  gate;

  assign full     = (held == HELD_W'(MAX_JETS));
  assign busy     = v0 || v1 || v2 || v3;
  assign out_free = !results.valid || results.ready;
  assign issue    = (state == ST_PAIR);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  // event result goes out once the pipeline is empty and the output is free
  assign emit     = (state == ST_CLOSE) && !busy && out_free;

  // jet store: written on arrival, read one stored jet per pair cycle
  always_ff @(posedge clk) begin
    if (q_pop && q_item.present && !full) begin
      mem[held[IDX_W-1:0]] <= q_item.jet;
    end
    rd_jet <= mem[idx];
    c0     <= cur;
  end

  // gap and hemisphere tests on the raw pseudorapidities
  always_comb begin
    eta_diff = $signed({c0.eta[ETA_W-1], c0.eta}) - $signed({rd_jet.eta[ETA_W-1], rd_jet.eta});
    eta_gap  = eta_diff[ETA_W] ? $unsigned(-eta_diff) : $unsigned(eta_diff);
    cur_neg  = c0.eta[ETA_W-1];
    cur_pos  = !c0.eta[ETA_W-1] && (c0.eta != '0);
    old_neg  = rd_jet.eta[ETA_W-1];
    old_pos  = !rd_jet.eta[ETA_W-1] && (rd_jet.eta != '0);
    gate     = (eta_gap > {1'b0, min_eta_gap}) &&
               ((cur_neg && old_pos) || (cur_pos && old_neg));
  end

  // four-vector sums, squares, then mass squared against threshold squared
  always_ff @(posedge clk) begin
    s1_x <= $signed({c0.x[MOM_W-1], c0.x}) + $signed({rd_jet.x[MOM_W-1], rd_jet.x});
    s1_y <= $signed({c0.y[MOM_W-1], c0.y}) + $signed({rd_jet.y[MOM_W-1], rd_jet.y});
    s1_z <= $signed({c0.z[MOM_W-1], c0.z}) + $signed({rd_jet.z[MOM_W-1], rd_jet.z});
    s1_e <= $signed({2'b00, c0.e} + {2'b00, rd_jet.e});
    g1   <= gate;
    sq_x <= s1_x * s1_x;
    sq_y <= s1_y * s1_y;
    sq_z <= s1_z * s1_z;
    sq_e <= s1_e * s1_e;
    g2   <= g1;
    a3   <= $signed({sq_e[SQ_W-1], sq_e}) - $signed({sq_x[SQ_W-1], sq_x});
    b3   <= {1'b0, $unsigned(sq_y)} + {1'b0, $unsigned(sq_z)};
    g3   <= g2;
  end

  assign m2    = $signed({a3[SQ_W], a3}) - $signed({1'b0, b3});
  assign good3 = g3 && (m2 > $signed({{(M2_W - THR_W){1'b0}}, thr2}));

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      held          <= '0;
      tally         <= '0;
      overflow      <= 1'b0;
      v0            <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      if (emit) begin
        results.valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      if (v3 && good3 && (tally != TALLY_MAX)) begin
        tally <= tally + 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.present && full) begin
              overflow <= 1'b1;
              state    <= q_item.last ? ST_CLOSE : ST_IDLE;
            end else if (q_item.present) begin
              held <= held + 1'b1;
              if (held != '0) begin
                state <= ST_PAIR;
              end else begin
                state <= q_item.last ? ST_CLOSE : ST_IDLE;
              end
            end else begin
              state <= q_item.last ? ST_CLOSE : ST_IDLE;
            end
          end
        end
        ST_PAIR: begin
          if (idx == pair_end) begin
            state <= cur_last ? ST_CLOSE : ST_IDLE;
          end
        end
        ST_CLOSE: begin
          if (emit) begin
            held     <= '0;
            tally    <= '0;
            overflow <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_item.jet;
      cur_last <= q_item.last;
      idx      <= '0;
      pair_end <= held[IDX_W-1:0] - 1'b1;
    end else if (issue) begin
      idx <= idx + 1'b1;
    end
    if (emit) begin
      results.event_pass      <= (tally != '0);
      results.good_pair_count <= tally;
      results.jets_dropped    <= overflow;
    end
  end

  a_pair_needs_stored: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAIR) |-> (held != '0))
    else $error("pair cycle with an empty store");

  a_pair_index_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAIR) |-> (HELD_W'(idx) < held))
    else $error("pair index beyond the stored jets");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= HELD_W'(MAX_JETS))
    else $error("store count above capacity");

  a_close_drained: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(!busy))
    else $error("result issued with pairs still in the pipeline");

endmodule

`default_nettype wire
